// ===== src/psr_pkg.sv =====
// Package for the position step-rate controller: shared types and constants.
// No dependencies; used by every module of the block through scoped names.
package psr_pkg;

  localparam int SPEED_W = 11;
  localparam int CMP_W   = 11;

  // floor(1171876 / (1000 * s)) == floor(1171 / s) for any speed s
  localparam logic [SPEED_W-1:0] RATE_QUOT = 11'd1171;
  localparam logic [SPEED_W-1:0] MAX_SPEED_RST = 11'd150;
  localparam logic [63:0]        TARGET_RST = 64'd1440;

  typedef enum logic {
    REG_TARGET = 1'b0,
    REG_MAX_SPEED = 1'b1
  } psr_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIFF,
    ST_SPEED,
    ST_DIV,
    ST_DONE
  } psr_state_t;

  // error summary handed from the serial subtractor to the controller
  typedef struct packed {
    logic               negative;
    logic               zero;
    logic               big;
    logic [SPEED_W-1:0] mag_lo;
  } psr_diff_t;

endpackage

// ===== src/position_p_control_step_rate.sv =====
// Proportional position controller with step-rate output (top level).
// Each accepted word passes through the serial subtractor and then the divider; the
// divider is skipped when the speed is zero.
// New words are taken only when idle; a finished word waits while the
// output register still holds a stalled word, and the input stays stalled meanwhile.
// Reset (synchronous, rst_n low): target 1440, max_speed 150, held compare 0, empty.
module position_p_control_step_rate #(
  parameter int POSITION_WIDTH = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_wen,
  input  logic                        cfg_index,
  input  logic [(POSITION_WIDTH > psr_pkg::SPEED_W ? POSITION_WIDTH
                 : psr_pkg::SPEED_W)-1:0] cfg_wdata,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic signed [POSITION_WIDTH-1:0] in_cur_position,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        out_step_direction,
  output logic                        out_step_enable,
  output logic [psr_pkg::CMP_W-1:0]   out_compare_value,
  output logic                        out_at_target
);

  localparam int SW    = psr_pkg::SPEED_W;

  psr_pkg::psr_state_t state_r;
  psr_pkg::psr_state_t state_nxt;

  logic [POSITION_WIDTH-1:0] target_r;
  logic [SW-1:0]             max_speed_r;
  logic [psr_pkg::CMP_W-1:0] held_r;
  logic [SW-1:0]             speed_r;
  logic                      neg_r;
  logic                      zero_r;
  logic                      out_valid_r;
  logic                      out_dir_r;
  logic                      out_en_r;
  logic [psr_pkg::CMP_W-1:0] out_cmp_r;
  logic                      out_at_r;

  logic               in_accept;
  logic               out_take;
  logic               out_load;
  logic               div_start;
  logic               diff_done;
  logic               div_done;
  psr_pkg::psr_diff_t diff_res;
  logic [SW-1:0]      quotient;
  logic [SW+2:0]      five_mag;
  logic [SW-1:0]      speed_c;

  psr_serial_diff #(
    .POSITION_WIDTH(POSITION_WIDTH)
  ) u_diff (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (in_accept),
    .cur    (in_cur_position),
    .tgt    (target_r),
    .done   (diff_done),
    .result (diff_res)
  );

  psr_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .divisor  (speed_r),
    .done     (div_done),
    .quotient (quotient)
  );

  // speed = min(5 * |error|, max_speed)
  always_comb begin
    five_mag = {1'b0, diff_res.mag_lo, 2'b00} + {3'b000, diff_res.mag_lo};
    if (diff_res.big || (five_mag > {3'b000, max_speed_r})) begin
      speed_c = max_speed_r;
    end else begin
      speed_c = five_mag[SW-1:0];
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      psr_pkg::ST_IDLE:  if (in_valid) state_nxt = psr_pkg::ST_DIFF;
      psr_pkg::ST_DIFF:  if (diff_done) state_nxt = psr_pkg::ST_SPEED;
      psr_pkg::ST_SPEED: begin
        state_nxt = (speed_r == '0) ? psr_pkg::ST_DONE : psr_pkg::ST_DIV;
      end
      psr_pkg::ST_DIV:   if (div_done) state_nxt = psr_pkg::ST_DONE;
      psr_pkg::ST_DONE:  if (!out_valid_r || !out_stall) state_nxt = psr_pkg::ST_IDLE;
      default:           state_nxt = psr_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall  = 1'b1;
    div_start = 1'b0;
    out_load  = 1'b0;
    unique case (state_r)
      psr_pkg::ST_IDLE:  in_stall = 1'b0;
      psr_pkg::ST_SPEED: div_start = (speed_r != '0);
      psr_pkg::ST_DONE:  out_load = !out_valid_r || !out_stall;
      default:           ;
    endcase
  end

  assign in_accept = in_valid && !in_stall;
  assign out_take  = out_valid_r && !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= psr_pkg::ST_IDLE;
      target_r    <= psr_pkg::TARGET_RST[POSITION_WIDTH-1:0];
      max_speed_r <= psr_pkg::MAX_SPEED_RST;
      held_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wen) begin
        unique case (psr_pkg::psr_reg_t'(cfg_index))
          psr_pkg::REG_TARGET:    target_r <= cfg_wdata[POSITION_WIDTH-1:0];
          psr_pkg::REG_MAX_SPEED: max_speed_r <= cfg_wdata[SW-1:0];
          default:                ;
        endcase
      end
      // compare = q - 1, floored at zero
      if (div_done) begin
        held_r <= (quotient == '0) ? '0 : quotient - 1'b1;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_take) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (diff_done) begin
      speed_r <= speed_c;
      neg_r   <= diff_res.negative;
      zero_r  <= diff_res.zero;
    end
    if (out_load) begin
      out_dir_r <= ~neg_r;
      out_en_r  <= (speed_r != '0);
      out_cmp_r <= held_r;
      out_at_r  <= zero_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_step_direction = out_dir_r;
  assign out_step_enable    = out_en_r;
  assign out_compare_value  = out_cmp_r;
  assign out_at_target      = out_at_r;

endmodule

// ===== src/psr_serial_diff.sv =====
// Bit-serial subtractor: forms cur - target and target - cur LSB first.
// Depends on psr_pkg for the result struct and the speed width.
module psr_serial_diff #(
  parameter int POSITION_WIDTH = 32
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [POSITION_WIDTH-1:0] cur,
  input  logic [POSITION_WIDTH-1:0] tgt,
  output logic                      done,
  output psr_pkg::psr_diff_t        result
);

  localparam int SW    = psr_pkg::SPEED_W;
  localparam int NBITS = (POSITION_WIDTH + 1 > SW) ? POSITION_WIDTH + 1 : SW;
  localparam int CNT_W = $clog2(NBITS);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(NBITS - 1);

  logic                      busy_r;
  logic                      done_r;
  logic [CNT_W-1:0]          cnt_r;
  logic [POSITION_WIDTH-1:0] a_r;
  logic [POSITION_WIDTH-1:0] b_r;
  logic                      cd_r;
  logic                      cn_r;
  logic [SW-1:0]             lo_d_r;
  logic [SW-1:0]             lo_n_r;
  logic                      big_d_r;
  logic                      big_n_r;
  logic                      nz_r;
  logic                      sign_r;

  logic bit_d;
  logic bit_n;
  logic cd_nxt;
  logic cn_nxt;

  always_comb begin
    // a - b and b - a, each as x + ~y + carry
    bit_d  = a_r[0] ^ ~b_r[0] ^ cd_r;
    cd_nxt = (a_r[0] & ~b_r[0]) | (a_r[0] & cd_r) | (~b_r[0] & cd_r);
    bit_n  = b_r[0] ^ ~a_r[0] ^ cn_r;
    cn_nxt = (b_r[0] & ~a_r[0]) | (b_r[0] & cn_r) | (~a_r[0] & cn_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && (cnt_r == LAST);
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == LAST) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r     <= cur;
      b_r     <= tgt;
      cd_r    <= 1'b1;
      cn_r    <= 1'b1;
      big_d_r <= 1'b0;
      big_n_r <= 1'b0;
      nz_r    <= 1'b0;
    end else if (busy_r) begin
      // arithmetic shift: sign-extend past the top bit
      a_r    <= {a_r[POSITION_WIDTH-1], a_r[POSITION_WIDTH-1:1]};
      b_r    <= {b_r[POSITION_WIDTH-1], b_r[POSITION_WIDTH-1:1]};
      cd_r   <= cd_nxt;
      cn_r   <= cn_nxt;
      nz_r   <= nz_r | bit_d;
      sign_r <= bit_d;
      if (cnt_r < CNT_W'(SW)) begin
        lo_d_r <= {bit_d, lo_d_r[SW-1:1]};
        lo_n_r <= {bit_n, lo_n_r[SW-1:1]};
      end else begin
        big_d_r <= big_d_r | bit_d;
        big_n_r <= big_n_r | bit_n;
      end
    end
  end

  assign done            = done_r;
  assign result.negative = sign_r;
  assign result.zero     = ~nz_r;
  assign result.big      = sign_r ? big_n_r : big_d_r;
  assign result.mag_lo   = sign_r ? lo_n_r : lo_d_r;

endmodule

// ===== src/psr_divider.sv =====
// Restoring divider: 1171 / divisor, one quotient bit per cycle.
// Depends on psr_pkg for the dividend constant and the speed width.
module psr_divider (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [psr_pkg::SPEED_W-1:0]  divisor,
  output logic                         done,
  output logic [psr_pkg::SPEED_W-1:0]  quotient
);

  localparam int SW    = psr_pkg::SPEED_W;
  localparam int CNT_W = $clog2(SW);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(SW - 1);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [SW-1:0]    dvd_r;
  logic [SW-1:0]    dvs_r;
  logic [SW-1:0]    rem_r;
  logic [SW-1:0]    quo_r;

  logic [SW:0] trial;
  logic        fits;

  always_comb begin
    trial = {rem_r, dvd_r[SW-1]};
    fits  = trial >= {1'b0, dvs_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && (cnt_r == LAST);
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == LAST) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= psr_pkg::RATE_QUOT;
      dvs_r <= divisor;
      rem_r <= '0;
      quo_r <= '0;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[SW-2:0], 1'b0};
      quo_r <= {quo_r[SW-2:0], fits};
      // remainder stays below the divisor, so it fits in SW bits
      rem_r <= fits ? SW'(trial - {1'b0, dvs_r}) : trial[SW-1:0];
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule
